[hw/rtl/ctmc_pkg.sv]
// Shared constants, register codes and inter-stage types for the cooling thermostat.
package ctmc_pkg;

  localparam logic [31:0]        DISCONNECT_TOLERANCE_MS = 32'd10000;
  localparam logic signed [16:0] HALF_DEGREE             = 17'sd8;
  localparam logic [31:0]        MIN_TIME_MS             = 32'd180000;

  // floor(x / 1000) == (x * ceil(2^38 / 1000)) >> 38 for every 32-bit x
  localparam int               SEC_W        = 23;
  localparam int               MS_DIV_SHIFT = 38;
  localparam int               MS_PROD_W    = 61;
  localparam logic [28:0]      MS_DIV_MUL   = 29'd274877907;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_TEMP       = 3'd0,
    CFG_MAX_IDLE_TEMP  = 3'd1,
    CFG_MIN_COOLING_MS = 3'd2,
    CFG_MIN_IDLE_MS    = 3'd3,
    CFG_COOLER_PRESENT = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_IDLE = 2'd1,
    MODE_COOL = 2'd2
  } mode_t;

  typedef struct packed {
    logic signed [15:0] set_temp;
    logic signed [15:0] max_idle_temp;
    logic [31:0]        min_cooling_ms;
    logic [31:0]        min_idle_ms;
    logic               run_ok;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic               sample_valid;
    logic signed [15:0] room_temp;
  } item_t;

  typedef struct packed {
    logic        cooler_on;
    mode_t       mode;
    logic        sensor_lost;
    logic [31:0] elapsed_ms;
  } step_t;

endpackage

[hw/rtl/ctmc_cfg.sv]
// Configuration registers and the registered settings check.
module ctmc_cfg
  import ctmc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output cfg_t                 cfg
);

  logic signed [15:0] set_temp_r;
  logic signed [15:0] max_idle_temp_r;
  logic [31:0]        min_cooling_ms_r;
  logic [31:0]        min_idle_ms_r;
  logic               cooler_present_r;
  logic               run_ok_r;
  logic               run_ok_nxt;
  logic signed [16:0] set_plus_half;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_temp_r       <= '0;
      max_idle_temp_r  <= '0;
      min_cooling_ms_r <= '0;
      min_idle_ms_r    <= '0;
      cooler_present_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SET_TEMP:       set_temp_r       <= $signed(cfg_data[15:0]);
        CFG_MAX_IDLE_TEMP:  max_idle_temp_r  <= $signed(cfg_data[15:0]);
        CFG_MIN_COOLING_MS: min_cooling_ms_r <= cfg_data;
        CFG_MIN_IDLE_MS:    min_idle_ms_r    <= cfg_data;
        CFG_COOLER_PRESENT: cooler_present_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // settings need upper >= set + half a degree, both hold times long enough and a cooler present
  always_comb begin
    set_plus_half = 17'(set_temp_r) + HALF_DEGREE;
    run_ok_nxt    = (set_plus_half <= 17'(max_idle_temp_r)) &&
                    (min_cooling_ms_r >= MIN_TIME_MS) &&
                    (min_idle_ms_r >= MIN_TIME_MS) &&
                    cooler_present_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_ok_r <= 1'b0;
    end else begin
      run_ok_r <= run_ok_nxt;
    end
  end

  always_comb begin
    cfg.set_temp       = set_temp_r;
    cfg.max_idle_temp  = max_idle_temp_r;
    cfg.min_cooling_ms = min_cooling_ms_r;
    cfg.min_idle_ms    = min_idle_ms_r;
    cfg.run_ok         = run_ok_r;
  end

endmodule

[hw/rtl/ctmc_ctrl.sv]
// Thermostat decision logic, cooler state and the middle pipeline register.
module ctmc_ctrl
  import ctmc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  item_valid,
  input  item_t item,
  input  logic  load,
  output logic  step_valid,
  output step_t step
);

  logic        cooling_r;
  logic        cooling_nxt;
  logic [31:0] last_switch_r;
  logic [31:0] last_switch_nxt;
  logic [31:0] last_valid_r;
  logic [31:0] last_valid_nxt;
  logic        step_valid_r;
  step_t       step_r;
  step_t       step_nxt;

  logic        fire;
  logic [31:0] since_valid;
  logic [31:0] since_switch;
  logic        lost;
  logic        too_cold;
  logic        too_warm;
  logic        turn_off;
  logic        turn_on;
  logic        toggle;
  logic        cool_after;

  assign fire = item_valid && load;

  always_comb begin
    since_valid  = item.now_ms - last_valid_r;
    since_switch = item.now_ms - last_switch_r;
    lost         = !item.sample_valid && (since_valid >= DISCONNECT_TOLERANCE_MS);
    too_cold     = item.sample_valid && ($signed(item.room_temp) <= $signed(cfg.set_temp));
    too_warm     = !lost && item.sample_valid &&
                   ($signed(item.room_temp) > $signed(cfg.max_idle_temp));
    turn_off     = cooling_r && (lost || too_cold) && (since_switch > cfg.min_cooling_ms);
    turn_on      = !cooling_r && too_warm && (since_switch > cfg.min_idle_ms);
    toggle       = turn_off || turn_on;
    cool_after   = cooling_r ^ toggle;
  end

  // next state: bad settings freeze the cooler state and both timestamps
  always_comb begin
    cooling_nxt     = cooling_r;
    last_switch_nxt = last_switch_r;
    last_valid_nxt  = last_valid_r;
    if (fire && cfg.run_ok) begin
      cooling_nxt = cool_after;
      if (toggle) begin
        last_switch_nxt = item.now_ms;
      end
      if (item.sample_valid) begin
        last_valid_nxt = item.now_ms;
      end else if (lost) begin
        last_valid_nxt = item.now_ms - DISCONNECT_TOLERANCE_MS;
      end
    end
  end

  always_comb begin
    step_nxt = '0;
    step_nxt.mode = MODE_OFF;
    if (cfg.run_ok) begin
      step_nxt.cooler_on   = cool_after;
      step_nxt.mode        = cool_after ? MODE_COOL : MODE_IDLE;
      step_nxt.sensor_lost = lost;
      step_nxt.elapsed_ms  = toggle ? 32'd0 : since_switch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cooling_r     <= 1'b0;
      last_switch_r <= '0;
      last_valid_r  <= '0;
      step_valid_r  <= 1'b0;
    end else begin
      cooling_r     <= cooling_nxt;
      last_switch_r <= last_switch_nxt;
      last_valid_r  <= last_valid_nxt;
      if (load) begin
        step_valid_r <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      step_r <= step_nxt;
    end
  end

  assign step_valid = step_valid_r;
  assign step       = step_r;

  a_cool_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(cooling_r))
    else $error("cooler state changed without a request");

  a_switch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    fire && cfg.run_ok && toggle |=> step_r.elapsed_ms == 32'd0)
    else $error("switch step reports nonzero elapsed time");

  a_off_blank: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !cfg.run_ok |=> step_r.mode == MODE_OFF && !step_r.cooler_on)
    else $error("invalid settings did not report off");

  a_mode_match: assert property (@(posedge clk) disable iff (!rst_n)
    fire && cfg.run_ok |=> step_r.cooler_on == cooling_r)
    else $error("reported cooler drive differs from state");

endmodule

[hw/rtl/ctmc_sec.sv]
// Milliseconds-to-seconds conversion by reciprocal multiply and the output register.
module ctmc_sec
  import ctmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_valid,
  input  step_t       step,
  output logic        load,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata
);

  logic                 out_valid_r;
  logic [31:0]          out_data_r;
  logic [MS_PROD_W-1:0] prod;
  logic [SEC_W-1:0]     seconds;

  assign load = !out_valid_r || out_tready;

  always_comb begin
    prod    = MS_PROD_W'(step.elapsed_ms) * MS_PROD_W'(MS_DIV_MUL);
    seconds = prod[MS_DIV_SHIFT +: SEC_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= step_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && step_valid) begin
      out_data_r <= {5'd0, step.sensor_lost, seconds, step.mode, step.cooler_on};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[hw/rtl/cooling_thermostat_min_cycle.sv]
// Top level of the on/off cooling thermostat with minimum on and off times.
//
//  channel | handshake            | payload
//  in_     | in_tvalid/in_tready  | tdata[31:0] now_ms, [47:32] room_temp; tuser sample_valid
//  out_    | out_tvalid/out_tready| tdata[0] cooler_on, [2:1] mode, [25:3] seconds, [26] lost
//  cfg_    | cfg_valid/cfg_ready  | cfg_index register, cfg_data value
//
// One request per cycle unless the output stalls; out_tvalid rises once its request is taken and has passed
// the input register, then the decision stage, then the seconds multiply into the output register.
// Reset clears the cooler state, the timestamps and all settings.
// Each stage holds when the stage after it is full and stalled, so bubbles close up.
// Settings registers update on the write edge; the registered validity check follows in the next cycle.
module cooling_thermostat_min_cycle
  import ctmc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [47:0]          in_tdata,   // now_ms[31:0], room_temp[47:32]
  input  logic                 in_tuser,   // sample_valid
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,  // cooler_on, mode, seconds_since_switch, sensor_lost
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cfg_t  cfg;
  logic  in_valid_r;
  item_t in_item_r;
  logic  step_valid;
  step_t step;
  logic  step_load;
  logic  out_load;

  // middle stage frees when empty or when the output stage can take it
  assign step_load = !step_valid || out_load;
  assign in_tready = !in_valid_r || step_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.now_ms       <= in_tdata[31:0];
      in_item_r.room_temp    <= $signed(in_tdata[47:32]);
      in_item_r.sample_valid <= in_tuser;
    end
  end

  ctmc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ctmc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (in_valid_r),
    .item       (in_item_r),
    .load       (step_load),
    .step_valid (step_valid),
    .step       (step)
  );

  ctmc_sec u_sec (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_valid (step_valid),
    .step       (step),
    .load       (out_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
